[rtl/slpl_pkg.sv]
// Shared types and constants for the stereo lookahead peak limiter.
// No dependencies; used by slpl_div and the top level of the block.
package slpl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_DIV,
    ST_COEF,
    ST_MIX,
    ST_ENV,
    ST_GAIN,
    ST_OUT
  } state_t;

  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int ENV_W    = 24;
  localparam int COEF_W   = 24;
  localparam int THR_W    = 24;
  localparam int DLY_W    = 9;
  localparam int GAIN_W   = 17;
  localparam int QUO_BITS = 23;
  localparam int CNT_W    = 32;
  localparam int GAIN_SH  = 16;

  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_RELEASE   = 3'd3;
  localparam logic [2:0] REG_DELAY     = 3'd4;

  localparam logic [ENV_W-1:0]  UNITY_Q23   = 24'd8388608;
  localparam logic [ENV_W-1:0]  LIMIT_LEVEL = 24'd8380220;
  localparam logic [ENV_W-1:0]  GAIN_RND    = 24'd64;
  localparam logic [THR_W-1:0]  THR_RESET   = 24'd7476604;
  localparam logic [COEF_W-1:0] COEF_RESET  = 24'hFFFFFF;
  localparam logic [DLY_W-1:0]  DLY_RESET   = 9'd128;

endpackage

[rtl/slpl_in_if.sv]
// Input stream interface: one stereo frame per transaction.
// Depends on nothing; width set by SAMPLE_BITS.
interface slpl_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink (input valid, left_in, right_in, output ready);
endinterface

[rtl/slpl_out_if.sv]
// Result stream interface: limited stereo frame and status per transaction.
// Depends on nothing; width set by SAMPLE_BITS.
interface slpl_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          limiting;
  logic                          limit_start;
  logic [31:0]                   over_count;

  modport source (output valid, left_out, right_out, limiting, limit_start, over_count,
                  input ready);
  modport sink (input valid, left_out, right_out, limiting, limit_start, over_count,
                output ready);
endinterface

[rtl/slpl_div.sv]
// Restoring divider, one quotient bit per cycle, for the limiter target gain.
// Depends on slpl_pkg; expects num < den so the quotient fits QUO_BITS.
module slpl_div #(
  parameter int CW = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [CW-1:0]                   num,
  input  logic [CW-1:0]                   den,
  output logic                            done,
  output logic [slpl_pkg::QUO_BITS-1:0]   quo
);

  localparam int QB = slpl_pkg::QUO_BITS;
  localparam int NW = $clog2(QB + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] den_r;
  logic [QB-1:0] q_r, q_nxt;
  logic [CW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r, 1'b0};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(QB);
      rem_nxt  = num;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? CW'(rem_sh - {1'b0, den_r}) : rem_sh[CW-1:0];
      q_nxt   = {q_r[QB-2:0], fits};
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[rtl/stereo_lookahead_peak_limiter_unit.sv]
// Top level of the stereo lookahead peak limiter: config registers, delay memory,
// envelope datapath and control. Depends on slpl_pkg, slpl_in_if, slpl_out_if, slpl_div.
//
// One frame is in flight at a time. A frame whose peak stays at or below the threshold
// passes through the states PEAK, COEF, MIX, ENV, GAIN and OUT; a frame above the
// threshold also visits DIV after PEAK, where the bit-serial divide (23 quotient bits)
// forms threshold / peak. Bypass frames go from IDLE straight to OUT. A result that is
// held off by the sink holds the control in OUT. A new frame is accepted as soon as the
// control returns to idle, even while the previous result still waits in the output
// register. The lookahead delay lives in a single-port memory of MAX_DELAY_FRAMES stereo
// entries, read and written at the same address in the accepting cycle (old data
// returned). A fill count marks entries not yet written as zero, so there is no
// clearing pass after reset. Registers at byte address 4*i: enabled, threshold_level,
// attack_rate, release_rate, delay_frames; write with psel, penable and pwrite high.
module stereo_lookahead_peak_limiter_unit #(
  parameter int MAX_DELAY_FRAMES = 256,
  parameter int SAMPLE_BITS      = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  slpl_in_if.sink                         in_if,
  slpl_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slpl_pkg::CFG_AW-1:0]     paddr,
  input  logic [slpl_pkg::CFG_DW-1:0]     pwdata,
  output logic [slpl_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
  localparam int LW  = (AW + 1 > slpl_pkg::DLY_W) ? AW + 1 : slpl_pkg::DLY_W;
  localparam int CW  = (SB > slpl_pkg::THR_W) ? SB : slpl_pkg::THR_W;
  localparam int FW  = 2 * SB;
  localparam int PW  = SB + slpl_pkg::GAIN_W + 1;
  localparam int EW  = slpl_pkg::ENV_W;
  localparam int KW  = slpl_pkg::COEF_W;
  localparam int MAW = EW + KW;
  localparam int MBW = KW + 1 + EW;
  localparam int QB  = slpl_pkg::QUO_BITS;
  localparam int GW  = slpl_pkg::GAIN_W;

  // configuration registers
  logic                         enabled_r;
  logic [slpl_pkg::THR_W-1:0]   thr_r;
  logic [KW-1:0]                att_r;
  logic [KW-1:0]                rel_r;
  logic [slpl_pkg::DLY_W-1:0]   dly_r;
  logic                         cfg_wr;

  // control and state
  slpl_pkg::state_t             state_r, state_nxt;
  logic [AW-1:0]                wp_r, wp_nxt;
  logic [AW:0]                  hwm_r;
  logic [EW-1:0]                env_r;
  logic                         limit_active_r;
  logic [slpl_pkg::CNT_W-1:0]   over_total_r;
  logic                         out_valid_r;

  // datapath
  logic [FW-1:0]                mem [MAX_DELAY_FRAMES];
  logic [FW-1:0]                rd_r;
  logic                         rd_vld_r;
  logic                         byp_r;
  logic signed [SB-1:0]         l_r, r_r;
  logic [EW-1:0]                target_r;
  logic [MAW-1:0]               prod_a_r;
  logic [KW:0]                  cc_r;
  logic [MBW-1:0]               prod_b_r;
  logic                         start_r;
  logic [GW-1:0]                gain_r;
  logic signed [PW-1:0]         prod_l_r, prod_r_r;
  logic signed [SB-1:0]         out_l_r, out_r_r;
  logic                         out_lim_r, out_start_r;
  logic [slpl_pkg::CNT_W-1:0]   out_cnt_r;

  // combinational
  logic                         in_ready;
  logic                         in_acc;
  logic                         mem_en;
  logic                         div_start;
  logic                         div_done;
  logic [QB-1:0]                div_quo;
  logic                         out_load;
  logic [LW-1:0]                dly_ext, len, wp_inc;
  logic [CW-1:0]                mag_l, mag_r, peak;
  logic                         over;
  logic [KW-1:0]                coef;
  logic [MBW-1:0]               acc;
  logic [EW-1:0]                env_raw, env_nxt;
  logic                         lim_now;
  logic signed [SB-1:0]         dl, dr;
  logic signed [SB-1:0]         sat_l, sat_r;

  function automatic logic [CW-1:0] mag_f(input logic signed [SB-1:0] v);
    logic [SB-1:0] u;
    u = v[SB-1] ? SB'(-v) : SB'(v);
    return CW'(u);
  endfunction

  function automatic logic signed [SB-1:0] sat_f(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> slpl_pkg::GAIN_SH;
    if (s[PW-1:SB-1] == '0 || s[PW-1:SB-1] == '1) begin
      return s[SB-1:0];
    end else if (s[PW-1]) begin
      return {1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      thr_r     <= slpl_pkg::THR_RESET;
      att_r     <= slpl_pkg::COEF_RESET;
      rel_r     <= slpl_pkg::COEF_RESET;
      dly_r     <= slpl_pkg::DLY_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        slpl_pkg::REG_ENABLED:   enabled_r <= pwdata[0];
        slpl_pkg::REG_THRESHOLD: thr_r     <= pwdata[slpl_pkg::THR_W-1:0];
        slpl_pkg::REG_ATTACK:    att_r     <= pwdata[KW-1:0];
        slpl_pkg::REG_RELEASE:   rel_r     <= pwdata[KW-1:0];
        slpl_pkg::REG_DELAY:     dly_r     <= pwdata[slpl_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      slpl_pkg::REG_ENABLED:   prdata = slpl_pkg::CFG_DW'(enabled_r);
      slpl_pkg::REG_THRESHOLD: prdata = slpl_pkg::CFG_DW'(thr_r);
      slpl_pkg::REG_ATTACK:    prdata = slpl_pkg::CFG_DW'(att_r);
      slpl_pkg::REG_RELEASE:   prdata = slpl_pkg::CFG_DW'(rel_r);
      slpl_pkg::REG_DELAY:     prdata = slpl_pkg::CFG_DW'(dly_r);
      default:                 prdata = '0;
    endcase
  end

  // delay length and pointer advance
  assign dly_ext = LW'(dly_r);
  assign len     = (dly_ext == '0) ? LW'(1) :
                   (dly_ext > LW'(MAX_DELAY_FRAMES)) ? LW'(MAX_DELAY_FRAMES) : dly_ext;
  assign wp_inc  = LW'(wp_r) + LW'(1);
  assign wp_nxt  = (wp_inc >= len) ? '0 : wp_inc[AW-1:0];

  // peak detect and target
  assign mag_l = mag_f(l_r);
  assign mag_r = mag_f(r_r);
  assign peak  = (mag_l > mag_r) ? mag_l : mag_r;
  assign over  = peak > CW'(thr_r);

  slpl_div #(.CW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (CW'(thr_r)),
    .den   (peak),
    .done  (div_done),
    .quo   (div_quo)
  );

  // envelope
  assign coef    = (target_r < env_r) ? att_r : rel_r;
  assign acc     = MBW'(prod_a_r) + prod_b_r + MBW'(slpl_pkg::UNITY_Q23);
  assign env_raw = acc[MAW-1:KW];
  assign env_nxt = (env_raw == '0) ? EW'(1) : env_raw;
  assign lim_now = env_nxt < slpl_pkg::LIMIT_LEVEL;

  // delayed samples, zero until the entry has been written
  assign dl = rd_vld_r ? rd_r[FW-1:SB] : '0;
  assign dr = rd_vld_r ? rd_r[SB-1:0]  : '0;

  assign sat_l = sat_f(prod_l_r);
  assign sat_r = sat_f(prod_r_r);

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slpl_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = enabled_r ? slpl_pkg::ST_PEAK : slpl_pkg::ST_OUT;
        end
      end
      slpl_pkg::ST_PEAK: state_nxt = over ? slpl_pkg::ST_DIV : slpl_pkg::ST_COEF;
      slpl_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = slpl_pkg::ST_COEF;
        end
      end
      slpl_pkg::ST_COEF: state_nxt = slpl_pkg::ST_MIX;
      slpl_pkg::ST_MIX:  state_nxt = slpl_pkg::ST_ENV;
      slpl_pkg::ST_ENV:  state_nxt = slpl_pkg::ST_GAIN;
      slpl_pkg::ST_GAIN: state_nxt = slpl_pkg::ST_OUT;
      slpl_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = slpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state_r == slpl_pkg::ST_IDLE;
    in_acc    = in_if.valid && in_ready;
    mem_en    = in_acc && enabled_r;
    div_start = (state_r == slpl_pkg::ST_PEAK) && over;
    out_load  = (state_r == slpl_pkg::ST_OUT) && (!out_valid_r || out_if.ready);
  end

  assign in_if.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= slpl_pkg::ST_IDLE;
      wp_r           <= '0;
      hwm_r          <= '0;
      env_r          <= slpl_pkg::UNITY_Q23;
      limit_active_r <= 1'b0;
      over_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_en) begin
        wp_r <= wp_nxt;
        if ({1'b0, wp_r} == hwm_r) begin
          hwm_r <= hwm_r + (AW + 1)'(1);
        end
      end
      if (div_start) begin
        over_total_r <= over_total_r + slpl_pkg::CNT_W'(1);
      end
      if (state_r == slpl_pkg::ST_ENV) begin
        env_r          <= env_nxt;
        limit_active_r <= lim_now;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // delay memory: read old pair, write new pair at the same address
  always_ff @(posedge clk) begin
    if (mem_en) begin
      rd_r        <= mem[wp_r];
      mem[wp_r]   <= {in_if.left_in, in_if.right_in};
      rd_vld_r    <= {1'b0, wp_r} < hwm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      l_r   <= in_if.left_in;
      r_r   <= in_if.right_in;
      byp_r <= !enabled_r;
    end
    case (state_r)
      slpl_pkg::ST_PEAK: begin
        if (!over) begin
          target_r <= slpl_pkg::UNITY_Q23;
        end
      end
      slpl_pkg::ST_DIV: begin
        if (div_done) begin
          target_r <= (div_quo == '0) ? EW'(1) : EW'(div_quo);
        end
      end
      slpl_pkg::ST_COEF: begin
        prod_a_r <= coef * env_r;
        cc_r     <= {1'b1, {KW{1'b0}}} - {1'b0, coef};
      end
      slpl_pkg::ST_MIX: begin
        prod_b_r <= cc_r * target_r;
      end
      slpl_pkg::ST_ENV: begin
        start_r <= lim_now && !limit_active_r;
        gain_r  <= GW'((env_nxt + slpl_pkg::GAIN_RND) >> 7);
      end
      slpl_pkg::ST_GAIN: begin
        prod_l_r <= PW'(dl) * $signed({1'b0, gain_r});
        prod_r_r <= PW'(dr) * $signed({1'b0, gain_r});
      end
      default: ;
    endcase
    if (out_load) begin
      out_l_r     <= byp_r ? l_r : sat_l;
      out_r_r     <= byp_r ? r_r : sat_r;
      out_lim_r   <= limit_active_r;
      out_start_r <= !byp_r && start_r;
      out_cnt_r   <= over_total_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.left_out    = out_l_r;
  assign out_if.right_out   = out_r_r;
  assign out_if.limiting    = out_lim_r;
  assign out_if.limit_start = out_start_r;
  assign out_if.over_count  = out_cnt_r;

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> ##(QB + 1) div_done)
    else $error("divide did not finish on time");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, wp_r} <= hwm_r)
    else $error("write pointer ahead of fill count");

  a_start_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.limit_start |-> out_if.limiting)
    else $error("limit start without limiting");

  a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !enabled_r |=> $stable(over_total_r) && $stable(env_r) && $stable(wp_r))
    else $error("state changed on a bypass transaction");

endmodule
